// ===== rtl/pngse_pkg.sv =====
`timescale 1ns / 1ps

package pngse_pkg;

	localparam int MaxSide = 4096;
	localparam int SideW = 13;
	localparam int RawW = 27;
	localparam logic [15:0] BlockMax = 16'hFFFF;
	localparam logic [16:0] AdlerMod = 17'd65521;
	localparam logic [31:0] CrcPoly = 32'hEDB88320;
	localparam int CallLimit = 58;

	localparam logic RegWidth = 1'b0;
	localparam logic RegHeight = 1'b1;

	localparam logic [7:0] SigBytes [8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LATCH = 8'b0000_0010,
		S_MUL   = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_IDAT  = 8'b0001_0000,
		S_HDR   = 8'b0010_0000,
		S_RAW   = 8'b0100_0000,
		S_TAIL  = 8'b1000_0000
	} state_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
		end
		return c;
	endfunction

	function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] sel);
		logic [7:0] r;
		case (sel)
			2'd0: r = v[31:24];
			2'd1: r = v[23:16];
			2'd2: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
		logic [SideW-1:0] r;
		if (v == '0) begin
			r = SideW'(1);
		end else if (v > SideW'(MaxSide)) begin
			r = SideW'(MaxSide);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/png_stored_image_encoder_core.sv =====
`timescale 1ns / 1ps

// Streams a complete PNG file (signature, IHDR for 8-bit RGBA, one IDAT chunk of stored
// deflate blocks with zlib header and Adler-32 trailer, IEND) one byte per beat from ARGB
// pixels given in row-major order. The first pixel of a file latches image_width and
// image_height (0 counts as 1, above 4096 as 4096); writes later take effect at the next
// file. A single byte sequencer sharing one CRC-32 byte unit and one Adler-32 adder emits
// at most one byte per cycle while byte_ready allows; a pixel gives four bytes (five when
// it opens a row), plus five for each stored block header; the first pixel of a file adds
// 43 bytes of headers and the last one 20 of trailer. A call gives at most 58 bytes; the
// 1x1 image spills its last 15 bytes into the next pixel beat, whose pixel is ignored.
module png_stored_image_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_en,
	input  logic        cfg_addr,
	input  logic [12:0] cfg_data,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [31:0] pixel_argb,
	output logic        byte_valid,
	input  logic        byte_ready,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        file_end
);

	pngse_pkg::state_t state_q, nxt_state, resume_q;

	logic [12:0] width_q, height_q, lat_w_q, lat_h_q, col_q;
	logic [26:0] raw_q, raw_rem_q;
	logic [10:0] blk_q;
	logic [31:0] idat_q, crc_q, px_q;
	logic [15:0] bo_q, adl_lo_q, adl_hi_q;
	logic        hdr_sent_q, pend_q;
	logic [5:0]  idx_q, cnt_q;
	logic [2:0]  k_q, bh_q;
	logic        bv_q;

	logic        emit, upd, rst_crc, last_nat, fend, fire, cut, need_bh, is_data;
	logic [7:0]  b;
	logic [15:0] len16;
	logic [31:0] crc_base;
	logic [27:0] y, ysum;
	logic [16:0] lo_sum, hi_sum;
	logic [15:0] lo_n, hi_n;

	assign pixel_ready = (state_q == pngse_pkg::S_IDLE);
	assign byte_valid = bv_q;

	assign len16 = (raw_rem_q > 27'(pngse_pkg::BlockMax)) ? pngse_pkg::BlockMax : raw_rem_q[15:0];
	assign need_bh = (bo_q == 16'd0) && (bh_q < 3'd5);
	assign y = 28'(raw_q) + 28'd65534;
	assign ysum = y + (y >> 16) + 28'd1;

	always_comb begin
		emit = 1'b0;
		upd = 1'b0;
		rst_crc = 1'b0;
		last_nat = 1'b0;
		fend = 1'b0;
		is_data = 1'b0;
		b = 8'd0;
		case (state_q)
			pngse_pkg::S_HDR: begin
				emit = 1'b1;
				upd = ((idx_q >= 6'd12) && (idx_q <= 6'd28)) || (idx_q >= 6'd37);
				rst_crc = (idx_q == 6'd12) || (idx_q == 6'd37);
				case (idx_q)
					6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7:
						b = pngse_pkg::SigBytes[idx_q[2:0]];
					6'd11: b = 8'h0D;
					6'd12: b = 8'h49;
					6'd13: b = 8'h48;
					6'd14: b = 8'h44;
					6'd15: b = 8'h52;
					6'd16, 6'd17, 6'd18, 6'd19:
						b = pngse_pkg::be_byte({19'd0, lat_w_q}, idx_q[1:0]);
					6'd20, 6'd21, 6'd22, 6'd23:
						b = pngse_pkg::be_byte({19'd0, lat_h_q}, idx_q[1:0]);
					6'd24: b = 8'd8;
					6'd25: b = 8'd6;
					6'd29, 6'd30, 6'd31, 6'd32:
						b = pngse_pkg::be_byte(~crc_q, 2'(idx_q - 6'd29));
					6'd33, 6'd34, 6'd35, 6'd36:
						b = pngse_pkg::be_byte(idat_q, 2'(idx_q - 6'd33));
					6'd37: b = 8'h49;
					6'd38: b = 8'h44;
					6'd39: b = 8'h41;
					6'd40: b = 8'h54;
					6'd41: b = 8'h78;
					6'd42: b = 8'h01;
					default: b = 8'd0;
				endcase
			end
			pngse_pkg::S_RAW: begin
				emit = 1'b1;
				upd = 1'b1;
				if (need_bh) begin
					case (bh_q)
						3'd0: b = {7'd0, raw_rem_q <= 27'(pngse_pkg::BlockMax)};
						3'd1: b = len16[7:0];
						3'd2: b = len16[15:8];
						3'd3: b = ~len16[7:0];
						default: b = ~len16[15:8];
					endcase
				end else begin
					is_data = 1'b1;
					case (k_q)
						3'd1: b = px_q[23:16];
						3'd2: b = px_q[15:8];
						3'd3: b = px_q[7:0];
						3'd4: b = px_q[31:24];
						default: b = 8'd0;
					endcase
					last_nat = (k_q == 3'd4) && (raw_rem_q != 27'd1);
				end
			end
			pngse_pkg::S_TAIL: begin
				emit = 1'b1;
				upd = (idx_q <= 6'd3) || ((idx_q >= 6'd12) && (idx_q <= 6'd15));
				rst_crc = (idx_q == 6'd12);
				case (idx_q)
					6'd0, 6'd1, 6'd2, 6'd3:
						b = pngse_pkg::be_byte({adl_hi_q, adl_lo_q}, idx_q[1:0]);
					6'd4, 6'd5, 6'd6, 6'd7:
						b = pngse_pkg::be_byte(~crc_q, idx_q[1:0]);
					6'd12: b = 8'h49;
					6'd13: b = 8'h45;
					6'd14: b = 8'h4E;
					6'd15: b = 8'h44;
					6'd16, 6'd17, 6'd18, 6'd19:
						b = pngse_pkg::be_byte(~crc_q, idx_q[1:0]);
					default: b = 8'd0;
				endcase
				last_nat = (idx_q == 6'd19);
				fend = (idx_q == 6'd19);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign fire = emit && (!bv_q || byte_ready);
	assign cut = fire && !last_nat && (cnt_q == 6'(pngse_pkg::CallLimit - 1));
	assign crc_base = rst_crc ? 32'hFFFFFFFF : crc_q;

	assign lo_sum = {1'b0, adl_lo_q} + {9'd0, b};
	assign lo_n = (lo_sum >= pngse_pkg::AdlerMod) ? 16'(lo_sum - pngse_pkg::AdlerMod)
		: lo_sum[15:0];
	assign hi_sum = {1'b0, adl_hi_q} + {1'b0, lo_n};
	assign hi_n = (hi_sum >= pngse_pkg::AdlerMod) ? 16'(hi_sum - pngse_pkg::AdlerMod)
		: hi_sum[15:0];

	always_comb begin
		nxt_state = state_q;
		case (state_q)
			pngse_pkg::S_HDR: if (idx_q == 6'd42) nxt_state = pngse_pkg::S_RAW;
			pngse_pkg::S_RAW: begin
				if (is_data && (k_q == 3'd4)) begin
					nxt_state = (raw_rem_q == 27'd1) ? pngse_pkg::S_TAIL : pngse_pkg::S_IDLE;
				end
			end
			pngse_pkg::S_TAIL: if (idx_q == 6'd19) nxt_state = pngse_pkg::S_IDLE;
			default: nxt_state = state_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd1;
			height_q <= 13'd1;
		end else if (cfg_en) begin
			if (cfg_addr == pngse_pkg::RegHeight) height_q <= cfg_data;
			else width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pngse_pkg::S_IDLE;
			resume_q <= pngse_pkg::S_IDLE;
			pend_q <= 1'b0;
			hdr_sent_q <= 1'b0;
			bv_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			bh_q <= '0;
			col_q <= '0;
			bo_q <= '0;
			raw_rem_q <= '0;
			adl_lo_q <= 16'd1;
			adl_hi_q <= '0;
			crc_q <= 32'hFFFFFFFF;
			lat_w_q <= 13'd1;
			lat_h_q <= 13'd1;
		end else begin
			if (fire) begin
				bv_q <= 1'b1;
			end else if (byte_ready) begin
				bv_q <= 1'b0;
			end
			case (state_q)
				pngse_pkg::S_IDLE: begin
					if (pixel_valid) begin
						cnt_q <= '0;
						if (pend_q) begin
							pend_q <= 1'b0;
							state_q <= resume_q;
						end else if (!hdr_sent_q) begin
							state_q <= pngse_pkg::S_LATCH;
						end else begin
							state_q <= pngse_pkg::S_RAW;
							k_q <= (col_q == '0) ? 3'd0 : 3'd1;
							bh_q <= '0;
						end
					end
				end
				pngse_pkg::S_LATCH: begin
					lat_w_q <= pngse_pkg::clamp_side(width_q);
					lat_h_q <= pngse_pkg::clamp_side(height_q);
					col_q <= '0;
					bo_q <= '0;
					adl_lo_q <= 16'd1;
					adl_hi_q <= '0;
					state_q <= pngse_pkg::S_MUL;
				end
				pngse_pkg::S_MUL: state_q <= pngse_pkg::S_DIV;
				pngse_pkg::S_DIV: state_q <= pngse_pkg::S_IDAT;
				pngse_pkg::S_IDAT: begin
					raw_rem_q <= raw_q;
					hdr_sent_q <= 1'b1;
					idx_q <= '0;
					k_q <= '0;
					bh_q <= '0;
					state_q <= pngse_pkg::S_HDR;
				end
				default: begin
					if (fire) begin
						cnt_q <= cnt_q + 6'd1;
						if (upd) crc_q <= pngse_pkg::crc_byte(crc_base, b);
						idx_q <= (nxt_state != state_q) ? 6'd0 : idx_q + 6'd1;
						if (state_q == pngse_pkg::S_RAW) begin
							if (!is_data) begin
								bh_q <= bh_q + 3'd1;
							end else begin
								bh_q <= '0;
								k_q <= k_q + 3'd1;
								adl_lo_q <= lo_n;
								adl_hi_q <= hi_n;
								raw_rem_q <= raw_rem_q - 27'd1;
								bo_q <= (bo_q == pngse_pkg::BlockMax - 16'd1) ? 16'd0
									: bo_q + 16'd1;
								if (k_q == 3'd4) begin
									col_q <= (col_q + 13'd1 >= lat_w_q) ? 13'd0 : col_q + 13'd1;
								end
							end
						end
						if (state_q == pngse_pkg::S_TAIL && idx_q == 6'd19) begin
							hdr_sent_q <= 1'b0;
						end
						if (cut) begin
							pend_q <= 1'b1;
							resume_q <= nxt_state;
							state_q <= pngse_pkg::S_IDLE;
						end else begin
							state_q <= nxt_state;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && pixel_ready && !pend_q) px_q <= pixel_argb;
		if (state_q == pngse_pkg::S_MUL) begin
			raw_q <= 27'(lat_h_q * {lat_w_q, 2'b01});
		end
		if (state_q == pngse_pkg::S_DIV) blk_q <= ysum[26:16];
		if (state_q == pngse_pkg::S_IDAT) begin
			idat_q <= 32'd6 + 32'(raw_q) + 32'({blk_q, 2'b00}) + 32'(blk_q);
		end
		if (fire) begin
			out_byte <= b;
			run_last <= last_nat || cut;
			file_end <= fend;
		end
	end

endmodule
